>>> src/tlpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared constants and request codes of the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int TABLE_PAGES_DEF   = 16;
  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int DIR_SLOTS         = 1024;
  localparam int IDX_W             = 10;
  localparam int FRAME_W           = 20;
  localparam int FLAGS_W           = 12;
  localparam int ENTRY_W           = FRAME_W + FLAGS_W;

  localparam logic [1:0] REQ_MAP    = 2'd0;
  localparam logic [1:0] REQ_UNMAP  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

endpackage

>>> src/two_level_page_table_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_engine_core
// Directory and table page RAMs with a read-modify-write sequencer.
//
//   channel   ports                                          handshake
//   request   req_type, vaddr, paddr_frame, entry_flags      start / busy
//   result    found, frame_out, status                       done (1 cycle)
//
// Steps per transaction, from acceptance to the return to idle:
// unmap, map into an existing table, refused map, lookup without a table and
// unused codes end with the directory read; lookup with a table goes on to
// the table read (directory read, then table read); map needing a new table
// page runs the page clear sweep of 1024 table writes through the single
// write port, then writes the entry. Busy is high whenever the state is not idle.
// After reset busy stays high while all 1024 directory slots are cleared.
// The result strobe cannot be stalled; busy is the only backpressure.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_core #(
  parameter int TABLE_PAGES = tlpt_pkg::TABLE_PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic [31:0]                  vaddr,
  input  logic [tlpt_pkg::FRAME_W-1:0] paddr_frame,
  input  logic [tlpt_pkg::FLAGS_W-1:0] entry_flags,
  output logic                         done,
  output logic                         found,
  output logic [tlpt_pkg::FRAME_W-1:0] frame_out,
  output logic                         status
);

  localparam int PG_W    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int CNT_W   = $clog2(TABLE_PAGES + 1);
  localparam int IDX_W   = tlpt_pkg::IDX_W;
  localparam int DIR_W   = PG_W + 1;
  localparam int TADDR_W = PG_W + IDX_W;
  localparam int TDEPTH  = TABLE_PAGES * tlpt_pkg::ENTRIES_PER_TABLE;
  localparam int ENTRY_W = tlpt_pkg::ENTRY_W;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIR  = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;
  localparam logic [2:0] ST_TBL  = 3'd5;

  logic [2:0]                   state;
  logic [IDX_W-1:0]             cnt;
  logic [CNT_W-1:0]             next_free_page;
  logic [PG_W-1:0]              page;
  logic [1:0]                   req;
  logic [IDX_W-1:0]             di;
  logic [IDX_W-1:0]             ti;
  logic [ENTRY_W-1:0]           entry;

  logic                         dir_we;
  logic [IDX_W-1:0]             dir_waddr;
  logic [DIR_W-1:0]             dir_wdata;
  logic [IDX_W-1:0]             dir_raddr;
  logic [DIR_W-1:0]             dir_rdata;
  logic                         dir_valid;
  logic [PG_W-1:0]              dir_page;

  logic                         tbl_we;
  logic [TADDR_W-1:0]           tbl_waddr;
  logic [ENTRY_W-1:0]           tbl_wdata;
  logic [TADDR_W-1:0]           tbl_raddr;
  logic [ENTRY_W-1:0]           tbl_rdata;

  logic                         pool_empty;

  tlpt_ram #(
    .DEPTH  (tlpt_pkg::DIR_SLOTS),
    .ADDR_W (IDX_W),
    .DATA_W (DIR_W)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpt_ram #(
    .DEPTH  (TDEPTH),
    .ADDR_W (TADDR_W),
    .DATA_W (ENTRY_W)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign busy       = (state != ST_IDLE);
  assign dir_valid  = dir_rdata[DIR_W-1];
  assign dir_page   = dir_rdata[PG_W-1:0];
  assign pool_empty = (next_free_page >= CNT_W'(TABLE_PAGES));
  assign dir_raddr  = vaddr[31:22];
  assign tbl_raddr  = {dir_page, ti};

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = di;
    dir_wdata = {1'b1, next_free_page[PG_W-1:0]};
    if (state == ST_INIT) begin
      dir_we    = 1'b1;
      dir_waddr = cnt;
      dir_wdata = '0;
    end else if (state == ST_DIR && req == tlpt_pkg::REQ_MAP && !dir_valid && !pool_empty) begin
      dir_we = 1'b1;
    end
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = {page, ti};
    tbl_wdata = entry;
    case (state)
      ST_CLR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {page, cnt};
        tbl_wdata = '0;
      end
      ST_WR: begin
        tbl_we = 1'b1;
      end
      ST_DIR: begin
        tbl_waddr = {dir_page, ti};
        if (dir_valid && req == tlpt_pkg::REQ_MAP) begin
          tbl_we = 1'b1;
        end else if (dir_valid && req == tlpt_pkg::REQ_UNMAP) begin
          tbl_we    = 1'b1;
          tbl_wdata = '0;
        end
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INIT;
      cnt            <= '0;
      next_free_page <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_INIT: begin
          cnt <= cnt + IDX_W'(1);
          if (cnt == {IDX_W{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= ST_DIR;
          end
        end
        ST_DIR: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          if (req == tlpt_pkg::REQ_MAP && !dir_valid && !pool_empty) begin
            state          <= ST_CLR;
            done           <= 1'b0;
            cnt            <= '0;
            next_free_page <= next_free_page + CNT_W'(1);
          end else if (req == tlpt_pkg::REQ_LOOKUP && dir_valid) begin
            state <= ST_TBL;
            done  <= 1'b0;
          end
        end
        ST_CLR: begin
          cnt <= cnt + IDX_W'(1);
          if (cnt == {IDX_W{1'b1}}) begin
            state <= ST_WR;
          end
        end
        ST_WR: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        ST_TBL: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req   <= req_type;
      di    <= vaddr[31:22];
      ti    <= vaddr[21:12];
      entry <= {paddr_frame, entry_flags};
    end
    if (state == ST_DIR) begin
      page      <= next_free_page[PG_W-1:0];
      found     <= 1'b0;
      frame_out <= '0;
      status    <= (req == tlpt_pkg::REQ_MAP) && !dir_valid && pool_empty;
    end
    if (state == ST_TBL) begin
      found     <= (tbl_rdata != '0);
      frame_out <= tbl_rdata[ENTRY_W-1:tlpt_pkg::FLAGS_W];
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free_page <= CNT_W'(TABLE_PAGES))
    else $error("page pool count beyond pool size");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && status))
    else $error("lookup hit and pool error in one result");

  a_frame_hit: assert property (@(posedge clk) disable iff (rst)
    done && (frame_out != '0) |-> found)
    else $error("frame reported without a hit");

endmodule

>>> src/tlpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
